### sv/chte_pkg.sv
// Shared types and constants for the chained hash table engine.
`default_nettype none

package chte_pkg;

    localparam int KEY_W       = 32;
    localparam int VAL_W       = 32;
    localparam int TS_W        = 13;
    localparam int MULT_W      = 12;
    localparam int OUT_BIN_W   = 12;
    localparam int STATUS_W    = 3;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 13;
    localparam int CLASH_W     = 32;

    // Key digits are base 256, least significant first.
    localparam int DIGIT_BITS  = 8;
    localparam int DIGIT_COUNT = 4;
    localparam int DIG_IDX_W   = 2;

    // digit * multiplier plus running index: 20-bit product plus a 13-bit index.
    localparam int ACC_W       = DIGIT_BITS + MULT_W + 1;
    localparam int BIT_CNT_W   = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_TABLE_SIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_0     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_1     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_2     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MULT_3     = 3'd4;

    localparam logic [TS_W-1:0]   TS_RESET     = 13'd4096;
    localparam logic [MULT_W-1:0] MULT_0_RESET = 12'd1;
    localparam logic [MULT_W-1:0] MULT_1_RESET = 12'd257;
    localparam logic [MULT_W-1:0] MULT_2_RESET = 12'd1031;
    localparam logic [MULT_W-1:0] MULT_3_RESET = 12'd2053;

    typedef enum logic [STATUS_W-1:0] {
        ST_FOUND     = 3'd0,
        ST_NOT_FOUND = 3'd1,
        ST_INSERTED  = 3'd2,
        ST_CLASH     = 3'd3,
        ST_FULL      = 3'd4
    } t_status;

endpackage

`default_nettype wire

### sv/chte_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module chte_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                    i_clk,
    input  wire logic                                    i_we,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]                        i_wdata,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic      [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### sv/chained_hash_table_engine_core.sv
// Top level of the chained hash table engine: hash sequencer, bin and node stores.
// Per key digit up to the highest nonzero one: a multiply (S_MUL), then a restoring remainder
// (S_MOD); then the bin read (S_BIN_RD, S_BIN), S_NODE_RD and S_NODE per chain node visited
// on a lookup, and the output load (S_DONE). One transaction at a time; the next is accepted
// in the cycle after the output loads; a waiting result holds the sequencer until it is taken.
// Synchronous active-low reset restores the configuration, then clears one bin per cycle.
`default_nettype none

module chained_hash_table_engine_core
    import chte_pkg::*;
#(
    parameter int MAX_BINS   = 4096,
    parameter int NODE_COUNT = 65536
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_ready,
    input  wire logic                  i_req_type,
    input  wire logic [KEY_W-1:0]      i_key,
    input  wire logic [VAL_W-1:0]      i_value,
    output logic                       o_valid,
    input  wire logic                  i_ready,
    output logic [STATUS_W-1:0]        o_status,
    output logic [VAL_W-1:0]           o_found_value,
    output logic [OUT_BIN_W-1:0]       o_bin_index,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int BW      = $clog2(MAX_BINS);
    localparam int NW      = $clog2(NODE_COUNT);
    localparam int CW      = NW + 1;
    localparam int TS_MAX  = (1 << TS_W) - 1;
    localparam int MOD_CAP = (MAX_BINS > TS_MAX) ? TS_MAX : MAX_BINS;
    localparam int BIN_W   = CW + 2 * NW;
    localparam int KV_W    = KEY_W + VAL_W;

    typedef enum logic [8:0] {
        S_CLEAR   = 9'b000000001,
        S_IDLE    = 9'b000000010,
        S_MUL     = 9'b000000100,
        S_MOD     = 9'b000001000,
        S_BIN_RD  = 9'b000010000,
        S_BIN     = 9'b000100000,
        S_NODE_RD = 9'b001000000,
        S_NODE    = 9'b010000000,
        S_DONE    = 9'b100000000
    } t_state;

    typedef struct packed {
        logic [CW-1:0] count;
        logic [NW-1:0] head;
        logic [NW-1:0] tail;
    } t_bin_entry;

    // Control state.
    t_state              r_state, n_state;
    logic [BW-1:0]       r_clr_addr, n_clr_addr;
    logic [CW-1:0]       r_free, n_free;
    logic [CLASH_W-1:0]  r_clash, n_clash;
    logic                r_out_valid, n_out_valid;
    logic [TS_W-1:0]     r_table_size, n_table_size;
    logic [MULT_W-1:0]   r_mult [DIGIT_COUNT];
    logic [MULT_W-1:0]   n_mult [DIGIT_COUNT];

    // Transaction payload and datapath.
    logic                r_req, n_req;
    logic [KEY_W-1:0]    r_key, n_key;
    logic [VAL_W-1:0]    r_value, n_value;
    logic [KEY_W-1:0]    r_quo, n_quo;
    logic [TS_W-1:0]     r_idx, n_idx;
    logic [DIG_IDX_W-1:0] r_dig, n_dig;
    logic [ACC_W-1:0]    r_acc, n_acc;
    logic [TS_W-1:0]     r_rem, n_rem;
    logic [BIT_CNT_W-1:0] r_bit, n_bit;
    logic [NW-1:0]       r_ptr, n_ptr;
    logic [CW-1:0]       r_left, n_left;
    t_status             r_res_status, n_res_status;
    logic [VAL_W-1:0]    r_res_found, n_res_found;
    t_status             r_out_status, n_out_status;
    logic [VAL_W-1:0]    r_out_found, n_out_found;
    logic [OUT_BIN_W-1:0] r_out_bin, n_out_bin;

    logic [TS_W-1:0]     w_mod;
    logic [TS_W:0]       w_trial;
    logic [TS_W-1:0]     w_rem_next;
    logic [ACC_W-1:0]    w_product;
    logic                w_full;
    logic [NW-1:0]       w_new_node;
    logic [BW-1:0]       w_bin_addr;
    t_bin_entry          w_bin_rd;
    t_bin_entry          w_bin_wr;
    logic [BIN_W-1:0]    w_bin_rdata;
    logic                w_bin_we;
    logic [BW-1:0]       w_bin_waddr;
    logic                w_insert;
    logic                w_kv_we;
    logic [KV_W-1:0]     w_kv_rdata;
    logic                w_next_we;
    logic [NW-1:0]       w_next_rdata;

    // Table size zero acts as one; above the bin count it saturates.
    always_comb begin
        if (r_table_size == '0) begin
            w_mod = TS_W'(1);
        end else if (r_table_size > TS_W'(MOD_CAP)) begin
            w_mod = TS_W'(MOD_CAP);
        end else begin
            w_mod = r_table_size;
        end
    end

    // Shared unit: one multiply-add per digit, then a restoring remainder one bit a cycle.
    assign w_product = ACC_W'(r_quo[DIGIT_BITS-1:0]) * ACC_W'(r_mult[r_dig])
                     + ACC_W'(r_idx);
    assign w_trial   = {r_rem, r_acc[ACC_W-1]};
    assign w_rem_next = (w_trial >= {1'b0, w_mod}) ? TS_W'(w_trial - {1'b0, w_mod})
                                                   : TS_W'(w_trial);

    assign w_full     = (r_free == CW'(NODE_COUNT));
    assign w_new_node = NW'(r_free);
    assign w_bin_addr = BW'(r_idx);
    assign w_bin_rd   = t_bin_entry'(w_bin_rdata);
    assign w_insert   = (r_state == S_BIN) && r_req && !w_full;

    always_comb begin
        w_bin_we    = 1'b0;
        w_bin_waddr = w_bin_addr;
        w_bin_wr    = '0;
        if (r_state == S_CLEAR) begin
            w_bin_we    = 1'b1;
            w_bin_waddr = r_clr_addr;
        end else if (w_insert) begin
            w_bin_we       = 1'b1;
            w_bin_wr.count = CW'(w_bin_rd.count + 1'b1);
            w_bin_wr.head  = (w_bin_rd.count == '0) ? w_new_node : w_bin_rd.head;
            w_bin_wr.tail  = w_new_node;
        end
    end

    assign w_kv_we   = w_insert;
    assign w_next_we = w_insert && (w_bin_rd.count != '0);

    always_comb begin
        n_state      = r_state;
        n_clr_addr   = r_clr_addr;
        n_free       = r_free;
        n_clash      = r_clash;
        n_out_valid  = r_out_valid;
        n_table_size = r_table_size;
        n_mult       = r_mult;
        n_req        = r_req;
        n_key        = r_key;
        n_value      = r_value;
        n_quo        = r_quo;
        n_idx        = r_idx;
        n_dig        = r_dig;
        n_acc        = r_acc;
        n_rem        = r_rem;
        n_bit        = r_bit;
        n_ptr        = r_ptr;
        n_left       = r_left;
        n_res_status = r_res_status;
        n_res_found  = r_res_found;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_bin    = r_out_bin;

        if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TABLE_SIZE: n_table_size = i_cfg_data;
                CFG_MULT_0:     n_mult[0] = i_cfg_data[MULT_W-1:0];
                CFG_MULT_1:     n_mult[1] = i_cfg_data[MULT_W-1:0];
                CFG_MULT_2:     n_mult[2] = i_cfg_data[MULT_W-1:0];
                CFG_MULT_3:     n_mult[3] = i_cfg_data[MULT_W-1:0];
                default: ;
            endcase
        end

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_CLEAR: begin
                n_clr_addr = BW'(r_clr_addr + 1'b1);
                if (r_clr_addr == BW'(MAX_BINS - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    n_req   = i_req_type;
                    n_key   = i_key;
                    n_value = i_value;
                    n_quo   = i_key;
                    n_idx   = '0;
                    n_dig   = '0;
                    // A zero key has no digits and maps to bin zero.
                    n_state = (i_key == '0) ? S_BIN_RD : S_MUL;
                end
            end
            S_MUL: begin
                n_acc   = w_product;
                n_rem   = '0;
                n_bit   = BIT_CNT_W'(ACC_W - 1);
                n_state = S_MOD;
            end
            S_MOD: begin
                n_rem = w_rem_next;
                n_acc = r_acc << 1;
                n_bit = BIT_CNT_W'(r_bit - 1'b1);
                if (r_bit == '0) begin
                    n_idx = w_rem_next;
                    n_quo = r_quo >> DIGIT_BITS;
                    n_dig = DIG_IDX_W'(r_dig + 1'b1);
                    // Remaining zero digits leave the index unchanged, so stop early.
                    if (r_dig == DIG_IDX_W'(DIGIT_COUNT - 1) ||
                        (r_quo >> DIGIT_BITS) == '0) begin
                        n_state = S_BIN_RD;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_BIN_RD: begin
                n_state = S_BIN;
            end
            S_BIN: begin
                n_res_found = '0;
                if (!r_req) begin
                    if (w_bin_rd.count == '0) begin
                        n_res_status = ST_NOT_FOUND;
                        n_state      = S_DONE;
                    end else begin
                        n_ptr   = w_bin_rd.head;
                        n_left  = w_bin_rd.count;
                        n_state = S_NODE_RD;
                    end
                end else if (w_full) begin
                    n_res_status = ST_FULL;
                    n_state      = S_DONE;
                end else begin
                    n_free = CW'(r_free + 1'b1);
                    if (w_bin_rd.count == '0) begin
                        n_res_status = ST_INSERTED;
                    end else begin
                        n_res_status = ST_CLASH;
                        n_clash      = CLASH_W'(r_clash + 1'b1);
                    end
                    n_state = S_DONE;
                end
            end
            S_NODE_RD: begin
                n_state = S_NODE;
            end
            S_NODE: begin
                if (w_kv_rdata[KV_W-1:VAL_W] == r_key) begin
                    n_res_status = ST_FOUND;
                    n_res_found  = w_kv_rdata[VAL_W-1:0];
                    n_state      = S_DONE;
                end else if (r_left == CW'(1)) begin
                    n_res_status = ST_NOT_FOUND;
                    n_state      = S_DONE;
                end else begin
                    n_left  = CW'(r_left - 1'b1);
                    n_ptr   = w_next_rdata;
                    n_state = S_NODE_RD;
                end
            end
            S_DONE: begin
                // The result loads when the output register is empty or being taken; else the sequencer waits.
                if (!r_out_valid || i_ready) begin
                    n_out_status = r_res_status;
                    n_out_found  = r_res_found;
                    n_out_bin    = OUT_BIN_W'(r_idx);
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_clr_addr   <= '0;
            r_free       <= '0;
            r_clash      <= '0;
            r_out_valid  <= 1'b0;
            r_table_size <= TS_RESET;
            r_mult[0]    <= MULT_0_RESET;
            r_mult[1]    <= MULT_1_RESET;
            r_mult[2]    <= MULT_2_RESET;
            r_mult[3]    <= MULT_3_RESET;
        end else begin
            r_state      <= n_state;
            r_clr_addr   <= n_clr_addr;
            r_free       <= n_free;
            r_clash      <= n_clash;
            r_out_valid  <= n_out_valid;
            r_table_size <= n_table_size;
            r_mult       <= n_mult;
        end
    end

    always_ff @(posedge i_clk) begin
        r_req        <= n_req;
        r_key        <= n_key;
        r_value      <= n_value;
        r_quo        <= n_quo;
        r_idx        <= n_idx;
        r_dig        <= n_dig;
        r_acc        <= n_acc;
        r_rem        <= n_rem;
        r_bit        <= n_bit;
        r_ptr        <= n_ptr;
        r_left       <= n_left;
        r_res_status <= n_res_status;
        r_res_found  <= n_res_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_bin    <= n_out_bin;
    end

    // Bin store: chain length, head and tail node of each bin.
    chte_ram #(
        .WIDTH (BIN_W),
        .DEPTH (MAX_BINS)
    ) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_bin_we),
        .i_waddr (w_bin_waddr),
        .i_wdata (BIN_W'(w_bin_wr)),
        .i_raddr (w_bin_addr),
        .o_rdata (w_bin_rdata)
    );

    chte_ram #(
        .WIDTH (KV_W),
        .DEPTH (NODE_COUNT)
    ) u_kv_ram (
        .i_clk   (i_clk),
        .i_we    (w_kv_we),
        .i_waddr (w_new_node),
        .i_wdata ({r_key, r_value}),
        .i_raddr (r_ptr),
        .o_rdata (w_kv_rdata)
    );

    // Link store: the old tail points to the appended node.
    chte_ram #(
        .WIDTH (NW),
        .DEPTH (NODE_COUNT)
    ) u_next_ram (
        .i_clk   (i_clk),
        .i_we    (w_next_we),
        .i_waddr (w_bin_rd.tail),
        .i_wdata (w_new_node),
        .i_raddr (r_ptr),
        .o_rdata (w_next_rdata)
    );

    assign o_ready       = (r_state == S_IDLE);
    assign o_valid       = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_found;
    assign o_bin_index   = r_out_bin;

    a_free_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= CW'(NODE_COUNT))
        else $error("free node pointer ran past the node store");

    a_insert_allocates: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_insert |=> (r_free == CW'($past(r_free) + 1'b1)))
        else $error("accepted insert did not allocate exactly one node");

    a_rem_below_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MOD) |-> (r_rem < w_mod))
        else $error("partial remainder not below the table size");

    a_walk_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NODE) |-> (r_left != '0))
        else $error("chain walk visited a node beyond the bin count");

endmodule

`default_nettype wire

### verif/tb_top.sv
// Testbench for chained_hash_table_engine_core: directed and random lookup/insert traffic.
`timescale 1ns / 100ps

module tb_top
    import chte_pkg::*;
();

    localparam int BIN_SLOTS   = 4096;
    localparam int NODE_SLOTS  = 65536;
    localparam int CYCLE_LIMIT = 4000000;
    localparam int IDLE_PAUSE  = 4;

    localparam logic REQ_LOOKUP = 1'b0;
    localparam logic REQ_INSERT = 1'b1;

    typedef struct packed {
        t_status                status;
        logic [VAL_W-1:0]       found_value;
        logic [OUT_BIN_W-1:0]   bin_index;
    } t_hash_reply;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_ready;
    logic                  i_req_type = REQ_LOOKUP;
    logic [KEY_W-1:0]      i_key = '0;
    logic [VAL_W-1:0]      i_value = '0;
    logic                  o_valid;
    logic                  i_ready = 1'b1;
    logic [STATUS_W-1:0]   o_status;
    logic [VAL_W-1:0]      o_found_value;
    logic [OUT_BIN_W-1:0]  o_bin_index;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = CFG_TABLE_SIZE;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    chained_hash_table_engine_core #(
        .MAX_BINS   (BIN_SLOTS),
        .NODE_COUNT (NODE_SLOTS)
    ) u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_req_type    (i_req_type),
        .i_key         (i_key),
        .i_value       (i_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_bin_index   (o_bin_index),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Shadow copy of the table: configuration, bins and node store.
    int unsigned tbl_size = TS_RESET;
    int unsigned digit_weight [DIGIT_COUNT] = '{MULT_0_RESET, MULT_1_RESET,
                                                MULT_2_RESET, MULT_3_RESET};
    int unsigned bucket_first [BIN_SLOTS];
    int unsigned bucket_last  [BIN_SLOTS];
    int unsigned bucket_len   [BIN_SLOTS] = '{default: 0};
    logic [KEY_W-1:0] slot_key [NODE_SLOTS];
    logic [VAL_W-1:0] slot_val [NODE_SLOTS];
    int unsigned      slot_link [NODE_SLOTS];
    int unsigned      slots_used = 0;

    t_hash_reply      pending_replies [$];
    logic [KEY_W-1:0] stored_keys [$];
    int               mismatches = 0;
    int               cycle_cnt = 0;
    int               hold_req = 0;
    bit               no_idle = 1'b0;

    function automatic int unsigned bucket_of(input logic [KEY_W-1:0] key);
        longint unsigned modulus;
        longint unsigned acc;
        longint unsigned rest;
        int              i;
        modulus = (tbl_size == 0) ? 1 : tbl_size;
        if (modulus > BIN_SLOTS) modulus = BIN_SLOTS;
        acc  = 0;
        rest = key;
        for (i = 0; i < DIGIT_COUNT && rest != 0; i++) begin
            acc  = ((rest % 256) * digit_weight[i] + acc) % modulus;
            rest = rest / 256;
        end
        return int'(acc);
    endfunction

    // Applies one request to the shadow table and returns the reply it must produce.
    function automatic t_hash_reply predict_reply(input logic req, input logic [KEY_W-1:0] key,
                                                  input logic [VAL_W-1:0] val);
        t_hash_reply r;
        int unsigned b;
        int unsigned p;
        int unsigned k;
        bit          hit;
        b = bucket_of(key);
        r.bin_index   = b[OUT_BIN_W-1:0];
        r.found_value = '0;
        if (req == REQ_LOOKUP) begin
            r.status = ST_NOT_FOUND;
            p   = bucket_first[b];
            hit = 1'b0;
            for (k = 0; k < bucket_len[b] && !hit; k++) begin
                if (slot_key[p] == key) begin
                    hit           = 1'b1;
                    r.status      = ST_FOUND;
                    r.found_value = slot_val[p];
                end else begin
                    p = slot_link[p];
                end
            end
        end else if (slots_used >= NODE_SLOTS) begin
            r.status = ST_FULL;
        end else begin
            slot_key[slots_used]  = key;
            slot_val[slots_used]  = val;
            slot_link[slots_used] = 0;
            if (bucket_len[b] == 0) begin
                bucket_first[b] = slots_used;
                r.status        = ST_INSERTED;
            end else begin
                slot_link[bucket_last[b]] = slots_used;
                r.status                  = ST_CLASH;
            end
            bucket_last[b] = slots_used;
            bucket_len[b]  = bucket_len[b] + 1;
            slots_used     = slots_used + 1;
        end
        return r;
    endfunction

    function automatic void flag_field(input string name, input logic [31:0] want,
                                       input logic [31:0] got);
        if (got !== want) begin
            mismatches++;
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
        end
    endfunction

    // Result checker: every accepted reply is matched against the oldest prediction.
    always @(posedge i_clk) begin
        t_hash_reply want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_replies.size() == 0) begin
                mismatches++;
                $error("reply transaction with no request outstanding");
            end else begin
                want = pending_replies.pop_front();
                flag_field("status", 32'(want.status), 32'(o_status));
                flag_field("found_value", want.found_value, o_found_value);
                flag_field("bin_index", 32'(want.bin_index), 32'(o_bin_index));
            end
        end
    end

    // Reply side: random ready gaps, plus a long hold-off on request.
    initial begin : reply_sink
        int gap;
        forever begin
            @(posedge i_clk);
            if (hold_req > 0) begin
                gap      = hold_req;
                hold_req = 0;
                i_ready <= 1'b0;
                repeat (gap) @(posedge i_clk);
                i_ready <= 1'b1;
            end else if (o_valid && i_ready) begin
                gap = no_idle ? 0 : $urandom_range(0, 4);
                if (gap > 0) begin
                    i_ready <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                    i_ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("chained_hash_table_engine_core verification failed");
            $finish;
        end
    end

    // Offers one request; valid stays up across back-to-back transactions.
    task automatic send_request(input logic req, input logic [KEY_W-1:0] key,
                                input logic [VAL_W-1:0] val);
        int          gap;
        t_hash_reply rep;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_req_type <= req;
        i_key      <= key;
        i_value    <= val;
        do @(posedge i_clk); while (!o_ready);
        rep = predict_reply(req, key, val);
        pending_replies = {pending_replies, rep};
        if (req == REQ_INSERT) stored_keys = {stored_keys, key};
    endtask

    task automatic await_drain();
        i_valid <= 1'b0;
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (IDLE_PAUSE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_TABLE_SIZE: tbl_size        = data;
            CFG_MULT_0:     digit_weight[0] = data[MULT_W-1:0];
            CFG_MULT_1:     digit_weight[1] = data[MULT_W-1:0];
            CFG_MULT_2:     digit_weight[2] = data[MULT_W-1:0];
            CFG_MULT_3:     digit_weight[3] = data[MULT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_hash_setup(input logic [CFG_DATA_W-1:0] size,
                                   input logic [CFG_DATA_W-1:0] m0,
                                   input logic [CFG_DATA_W-1:0] m1,
                                   input logic [CFG_DATA_W-1:0] m2,
                                   input logic [CFG_DATA_W-1:0] m3);
        write_reg(CFG_TABLE_SIZE, size);
        write_reg(CFG_MULT_0, m0);
        write_reg(CFG_MULT_1, m1);
        write_reg(CFG_MULT_2, m2);
        write_reg(CFG_MULT_3, m3);
    endtask

    // Keys with 0 to 4 significant digits, so the hash runs for varying lengths.
    function automatic logic [KEY_W-1:0] random_key();
        logic [KEY_W-1:0] k;
        k = $urandom;
        case ($urandom_range(0, 5))
            0: k = '0;
            1: k = k & 32'h0000_00FF;
            2: k = k & 32'h0000_FFFF;
            3: k = k & 32'h00FF_FFFF;
            default: ;
        endcase
        return k;
    endfunction

    function automatic logic [VAL_W-1:0] random_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            default: return $urandom;
        endcase
    endfunction

    // Runs on the reset configuration: empty bins, key extremes, duplicates.
    task automatic test_reset_defaults();
        send_request(REQ_LOOKUP, 32'h0000_0000, 32'h1111_1111);
        send_request(REQ_INSERT, 32'h0000_0000, 32'hFFFF_FFFF);
        send_request(REQ_INSERT, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_LOOKUP, 32'h0000_0000, 32'h0000_0000);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h1234_5678);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        await_drain();
    endtask

    task automatic test_register_settings();
        int idx;
        // A table size of zero behaves as a single bin.
        load_hash_setup(13'd0, 13'd4095, 13'd4095, 13'd4095, 13'd4095);
        send_request(REQ_INSERT, 32'hDEAD_BEEF, 32'hCAFE_F00D);
        send_request(REQ_LOOKUP, 32'h0000_0001, 32'h0);
        await_drain();
        load_hash_setup(13'd1, 13'd0, 13'd0, 13'd0, 13'd0);
        send_request(REQ_LOOKUP, 32'hDEAD_BEEF, 32'h0);
        send_request(REQ_INSERT, 32'h8000_0000, 32'h8000_0001);
        await_drain();
        // Oversized table saturates; multipliers keep only their low 12 bits.
        load_hash_setup(13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF, 13'h1FFF);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        send_request(REQ_INSERT, 32'h0101_0101, 32'h5A5A_A5A5);
        await_drain();
        // Writes to unmapped indexes must leave every register alone.
        for (idx = int'(CFG_MULT_3) + 1; idx < (1 << CFG_IDX_W); idx++)
            write_reg(CFG_IDX_W'(idx), 13'd3);
        send_request(REQ_LOOKUP, 32'h0101_0101, 32'h0);
        await_drain();
        load_hash_setup(13'd4097, 13'd1, 13'd257, 13'd1031, 13'd2053);
        send_request(REQ_INSERT, 32'hFFFF_FFFF, 32'h0);
        await_drain();
        load_hash_setup(13'd4096, 13'd1, 13'd257, 13'd1031, 13'd2053);
        send_request(REQ_LOOKUP, 32'hFFFF_FFFF, 32'h0);
        await_drain();
    endtask

    task automatic test_random_traffic();
        int                    phase;
        int                    n;
        int                    pick;
        logic [CFG_DATA_W-1:0] size;
        logic [CFG_DATA_W-1:0] m [DIGIT_COUNT];
        for (phase = 0; phase < 7; phase++) begin
            foreach (m[i]) m[i] = CFG_DATA_W'($urandom_range(0, 4095));
            case (phase)
                0: size = CFG_DATA_W'($urandom_range(2, 16));
                1: size = 13'd1;
                2: begin
                    size = 13'd4096;
                    foreach (m[i]) m[i] = 13'd4095;
                end
                3: size = CFG_DATA_W'($urandom_range(2, 4095));
                4: size = 13'd0;
                5: begin
                    size = CFG_DATA_W'($urandom_range(4097, 8191));
                    foreach (m[i]) if ($urandom_range(0, 3) == 0) m[i] = 13'd0;
                end
                default: size = CFG_DATA_W'($urandom_range(17, 512));
            endcase
            load_hash_setup(size, m[0], m[1], m[2], m[3]);
            no_idle = (phase == 3);
            for (n = 0; n < 95; n++) begin
                pick = $urandom_range(0, 99);
                if (pick < 40)
                    send_request(REQ_INSERT, random_key(), random_value());
                else if (pick < 80 && stored_keys.size() > 0)
                    send_request(REQ_LOOKUP,
                                 stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                                 random_value());
                else if (pick < 88 && stored_keys.size() > 0)
                    send_request(REQ_INSERT,
                                 stored_keys[$urandom_range(0, stored_keys.size() - 1)],
                                 random_value());
                else
                    send_request(REQ_LOOKUP, random_key(), random_value());
            end
            await_drain();
        end
        no_idle = 1'b0;
    endtask

    // The reply side stalls for a long stretch while requests keep coming.
    task automatic test_reply_backpressure();
        int n;
        hold_req = 300;
        for (n = 0; n < 20; n++)
            send_request(($urandom_range(0, 1) == 1) ? REQ_INSERT : REQ_LOOKUP,
                         random_key(), random_value());
        await_drain();
    endtask

    initial begin
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_defaults();
        test_register_settings();
        test_random_traffic();
        test_reply_backpressure();
        if (mismatches == 0)
            $display("chained_hash_table_engine_core verification clean");
        else
            $display("chained_hash_table_engine_core verification failed");
        $finish;
    end

endmodule
